FILE: rtl/core/ssf_pkg.sv
package ssf_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned CHUNK_MAX_DEF   = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Packet framing
  localparam int unsigned PKT_LEN = 14;
  localparam logic [7:0]  HDR0    = 8'hAA;
  localparam logic [7:0]  HDR1    = 8'hBB;

  // Millivolts per volt, the divisor of the scaled product
  localparam logic [9:0] MV_PER_VOLT = 10'd1000;

  // Register reset values
  localparam logic [31:0] GAIN_HIGH_RST = 32'd818241123;
  localparam logic [31:0] GAIN_MID_RST  = 32'd314988190;
  localparam logic [31:0] GAIN_LOW_RST  = 32'd135601952;
  localparam logic [27:0] OFF_HIGH_RST  = 28'd90706372;
  localparam logic [27:0] OFF_MID_RST   = 28'd87672737;
  localparam logic [27:0] OFF_LOW_RST   = 28'd81147724;
  localparam logic [15:0] PERIOD_RST    = 16'd100;
  localparam logic [15:0] WINDOW_RST    = 16'd1000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_HIGH,
    CFG_GAIN_MID,
    CFG_GAIN_LOW,
    CFG_OFF_HIGH,
    CFG_OFF_MID,
    CFG_OFF_LOW,
    CFG_PERIOD,
    CFG_WINDOW
  } cfg_idx_e;

  // Input range selection
  typedef enum logic [1:0] {
    RANGE_HIGH,
    RANGE_MID,
    RANGE_LOW
  } range_e;

  // One measured sample handed from the front end to the back end
  typedef struct packed {
    logic [63:0] stamp;
    logic [11:0] mv;
    range_e      mode;
  } ssf_entry_t;

  // One finished packet payload
  typedef struct packed {
    logic [31:0] fbits;
    logic [63:0] stamp;
  } ssf_pkt_t;

  // Timestamp settings
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] window;
  } ssf_timing_t;

  // Calibration settings, indexed by range_e
  typedef struct packed {
    logic [2:0][31:0] gain;
    logic [2:0][27:0] offset;
  } ssf_cal_t;

endpackage

FILE: rtl/core/ssf_front.sv
module ssf_front #(
  parameter int unsigned CHUNK_MAX = ssf_pkg::CHUNK_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 first_i,
  input  logic [63:0]          now_i,
  input  logic [8:0]           count_i,
  input  logic [1:0]           mode_i,
  input  logic                 ok_i,
  input  logic [11:0]          mv_i,
  input  ssf_pkg::ssf_timing_t tcfg_i,
  output logic                 q_push_o,
  output ssf_pkg::ssf_entry_t  q_entry_o,
  input  logic                 q_full_i
);
  import ssf_pkg::*;

  logic        en;
  logic        accept;
  logic [8:0]  count_c;
  range_e      mode_c;
  logic [24:0] prod_c;

  // stage 1: item plus chunk duration
  logic        s1_vld_q;
  logic        s1_first_q;
  logic [63:0] s1_now_q;
  logic [24:0] s1_prod_q;
  logic        s1_ok_q;
  range_e      s1_mode_q;
  logic [11:0] s1_mv_q;

  // stage 2: item plus resync candidates
  logic        s2_vld_q;
  logic        s2_first_q;
  logic [63:0] s2_now_q;
  logic [63:0] s2_base_q;
  logic [63:0] s2_basep_q;
  logic        s2_ok_q;
  range_e      s2_mode_q;
  logic [11:0] s2_mv_q;

  logic [63:0] stamp_q, stamp_d;
  logic [63:0] stamp_use;
  logic [64:0] stamp_ext, now_ext, win_ext;
  logic        over;
  logic        resync;

  // the whole pipe holds only when a measured sample cannot enter the queue
  assign en     = !(s2_vld_q && s2_ok_q && q_full_i);
  assign full_o = !en;
  assign accept = push_i && en;

  // clamp chunk length, fold the unused range code onto the low range
  always_comb begin
    count_c = count_i;
    if (32'(count_i) > CHUNK_MAX) begin
      count_c = 9'(CHUNK_MAX);
    end
    case (mode_i)
      RANGE_HIGH: mode_c = RANGE_HIGH;
      RANGE_MID:  mode_c = RANGE_MID;
      default:    mode_c = RANGE_LOW;
    endcase
    prod_c = 25'(count_c) * 25'(tcfg_i.period);
  end

  // drift test and stamp update
  always_comb begin
    stamp_ext = {1'b0, stamp_q};
    now_ext   = {1'b0, s2_now_q};
    win_ext   = 65'(tcfg_i.window);
    over      = (now_ext > stamp_ext + win_ext) || (stamp_ext > now_ext + win_ext);
    resync    = s2_first_q && ((stamp_q == '0) || over);
    stamp_use = resync ? s2_base_q : stamp_q;
    stamp_d   = resync ? s2_basep_q : stamp_q + 64'(tcfg_i.period);
  end

  assign q_push_o  = en && s2_vld_q && s2_ok_q;
  assign q_entry_o = '{stamp: stamp_use, mv: s2_mv_q, mode: s2_mode_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      stamp_q  <= '0;
    end else if (en) begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q) begin
        stamp_q <= stamp_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_first_q <= first_i;
      s1_now_q   <= now_i;
      s1_prod_q  <= prod_c;
      s1_ok_q    <= ok_i;
      s1_mode_q  <= mode_c;
      s1_mv_q    <= mv_i;
      s2_first_q <= s1_first_q;
      s2_now_q   <= s1_now_q;
      s2_base_q  <= s1_now_q - 64'(s1_prod_q);
      s2_basep_q <= s1_now_q - 64'(s1_prod_q) + 64'(tcfg_i.period);
      s2_ok_q    <= s1_ok_q;
      s2_mode_q  <= s1_mode_q;
      s2_mv_q    <= s1_mv_q;
    end
  end

  // an item outside a chunk start always steps the stamp by one period
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_vld_q && !s2_first_q) |=>
      (stamp_q == $past(stamp_q + 64'(tcfg_i.period))))
    else $error("stamp did not advance by one period");

endmodule

FILE: rtl/core/ssf_queue.sv
module ssf_queue #(
  parameter int unsigned DEPTH = ssf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ssf_pkg::ssf_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output ssf_pkg::ssf_entry_t data_o,
  output logic                empty_o
);
  import ssf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssf_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("queue count lost a push");

endmodule

FILE: rtl/core/ssf_float.sv
module ssf_float (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_vld_i,
  output logic                in_rdy_o,
  input  ssf_pkg::ssf_entry_t entry_i,
  input  ssf_pkg::ssf_cal_t   cal_i,
  output logic                out_vld_o,
  input  logic                out_rdy_i,
  output ssf_pkg::ssf_pkt_t   out_pkt_o
);
  import ssf_pkg::*;

  localparam logic [2:0] NORM_STEPS = 3'd6;
  localparam logic [1:0] DIV_STEPS  = 2'd3;
  // bias 127, minus 40 fraction bits, plus quotient msb at bit 52
  localparam logic [7:0] EXP_BASE   = 8'd139;
  // 1000 = 8 * 125; floor(2^38 / 125) leaves the estimate exact or one short
  localparam logic [31:0] RECIP_125 = 32'd2199023255;
  localparam logic [7:0]  DIV_125   = 8'd125;

  // slot A: sign and magnitude of mV*2^16 - offset
  logic        a_vld_q, a_rdy;
  logic        a_sign_q;
  logic [27:0] a_mag_q;
  logic [31:0] a_gain_q;
  logic [63:0] a_stamp_q;
  logic [27:0] mvs, off_sel;
  logic [31:0] gain_sel;
  logic        neg;

  // slot B: full product
  logic        b_vld_q, b_rdy;
  logic        b_sign_q;
  logic [59:0] b_m_q;
  logic [63:0] b_stamp_q;

  // slot C: binary-search normalizer
  logic        c_vld_q, c_rdy, c_done;
  logic [2:0]  c_cnt_q;
  logic [62:0] c_word_q, word_n;
  logic [5:0]  c_sh_q, sh_n;
  logic        c_sign_q, c_zero_q;
  logic [63:0] c_stamp_q;

  // slot D: divide by 1000 as a shift by 3 and a reciprocal multiply for 125
  logic        d_vld_q, d_rdy, d_done;
  logic [1:0]  d_cnt_q;
  logic [31:0] d_y_q;
  logic [63:0] d_prod_q;
  logic [25:0] d_quot_q, quot_est;
  logic [7:0]  d_rem_q, rem_est;
  logic        d_lownz_q;
  logic [5:0]  d_sh_q;
  logic        d_sign_q, d_zero_q;
  logic [63:0] d_stamp_q;

  // rounding
  logic        hi, guard, sticky, up;
  logic [23:0] mant;
  logic [24:0] mant_r;
  logic [7:0]  expo;
  logic [31:0] fbits;

  // handshake chain
  assign d_done   = (d_cnt_q == DIV_STEPS);
  assign d_rdy    = !d_vld_q || (d_done && out_rdy_i);
  assign c_done   = (c_cnt_q == NORM_STEPS);
  assign c_rdy    = !c_vld_q || (c_done && d_rdy);
  assign b_rdy    = !b_vld_q || c_rdy;
  assign a_rdy    = !a_vld_q || b_rdy;
  assign in_rdy_o = a_rdy;

  // offset subtract
  always_comb begin
    off_sel  = cal_i.offset[entry_i.mode];
    gain_sel = cal_i.gain[entry_i.mode];
    mvs      = {entry_i.mv, 16'b0};
    neg      = (mvs < off_sel);
  end

  // normalize step: shift by 32, 16, 8, 4, 2, 1 when the top bits are clear
  always_comb begin
    word_n = c_word_q;
    sh_n   = c_sh_q;
    case (c_cnt_q)
      3'd0: if (c_word_q[62:31] == '0) begin
        word_n = c_word_q << 32;
        sh_n   = c_sh_q + 6'd32;
      end
      3'd1: if (c_word_q[62:47] == '0) begin
        word_n = c_word_q << 16;
        sh_n   = c_sh_q + 6'd16;
      end
      3'd2: if (c_word_q[62:55] == '0) begin
        word_n = c_word_q << 8;
        sh_n   = c_sh_q + 6'd8;
      end
      3'd3: if (c_word_q[62:59] == '0) begin
        word_n = c_word_q << 4;
        sh_n   = c_sh_q + 6'd4;
      end
      3'd4: if (c_word_q[62:61] == '0) begin
        word_n = c_word_q << 2;
        sh_n   = c_sh_q + 6'd2;
      end
      3'd5: if (!c_word_q[62]) begin
        word_n = c_word_q << 1;
        sh_n   = c_sh_q + 6'd1;
      end
      default: ;
    endcase
  end

  // quotient estimate for 125 and its remainder, below 250
  always_comb begin
    quot_est = d_prod_q[63:38];
    rem_est  = 8'(d_y_q - 32'(quot_est) * 32'(DIV_125));
  end

  // round to nearest even; the quotient has 25 or 26 significant bits
  always_comb begin
    hi     = d_quot_q[25];
    mant   = hi ? d_quot_q[25:2] : d_quot_q[24:1];
    guard  = hi ? d_quot_q[1] : d_quot_q[0];
    sticky = (hi && d_quot_q[0]) || (d_rem_q != '0) || d_lownz_q;
    up     = guard && (sticky || mant[0]);
    mant_r = {1'b0, mant} + 25'(up);
    expo   = EXP_BASE - {2'b0, d_sh_q} + {7'b0, hi} + {7'b0, mant_r[24]};
    fbits  = d_zero_q ? '0 : {d_sign_q, expo, mant_r[22:0]};
  end

  assign out_vld_o = d_vld_q && d_done;
  assign out_pkt_o = '{fbits: fbits, stamp: d_stamp_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      c_cnt_q <= '0;
      d_vld_q <= 1'b0;
      d_cnt_q <= '0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= in_vld_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
        c_cnt_q <= '0;
      end else if (c_vld_q && !c_done) begin
        c_cnt_q <= c_cnt_q + 1'b1;
      end
      if (d_rdy) begin
        d_vld_q <= c_vld_q && c_done;
        d_cnt_q <= '0;
      end else if (d_vld_q && !d_done) begin
        d_cnt_q <= d_cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (a_rdy && in_vld_i) begin
      a_sign_q  <= neg;
      a_mag_q   <= neg ? off_sel - mvs : mvs - off_sel;
      a_gain_q  <= gain_sel;
      a_stamp_q <= entry_i.stamp;
    end
    if (b_rdy && a_vld_q) begin
      b_sign_q  <= a_sign_q;
      b_m_q     <= 60'(a_mag_q) * 60'(a_gain_q);
      b_stamp_q <= a_stamp_q;
    end
    if (c_rdy && b_vld_q) begin
      c_word_q  <= {3'b0, b_m_q};
      c_sh_q    <= '0;
      c_sign_q  <= b_sign_q;
      c_zero_q  <= (b_m_q == '0);
      c_stamp_q <= b_stamp_q;
    end else if (c_vld_q && !c_done) begin
      c_word_q <= word_n;
      c_sh_q   <= sh_n;
    end
    // top 35 bits divided by 8, the rest only feeds the sticky bit
    if (d_rdy && c_vld_q && c_done) begin
      d_y_q     <= c_word_q[62:31];
      d_lownz_q <= (c_word_q[30:0] != '0);
      d_sh_q    <= c_sh_q;
      d_sign_q  <= c_sign_q;
      d_zero_q  <= c_zero_q;
      d_stamp_q <= c_stamp_q;
    end else if (d_vld_q && !d_done) begin
      case (d_cnt_q)
        2'd0: d_prod_q <= 64'(d_y_q) * 64'(RECIP_125);
        2'd1: begin
          d_quot_q <= quot_est;
          d_rem_q  <= rem_est;
        end
        default: if (d_rem_q >= DIV_125) begin
          d_quot_q <= d_quot_q + 1'b1;
          d_rem_q  <= d_rem_q - DIV_125;
        end
      endcase
    end
  end

  // a normalized nonzero product always leaves a quotient with its msb at 24 or 25
  a_quot_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_vld_q && d_done && !d_zero_q) |-> (d_quot_q[25] || d_quot_q[24]))
    else $error("divider quotient not normalized");

endmodule

FILE: rtl/core/ssf_serial.sv
module ssf_serial (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_vld_i,
  output logic              in_rdy_o,
  input  ssf_pkg::ssf_pkt_t pkt_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        byte_o,
  output logic              last_o
);
  import ssf_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(PKT_LEN - 1);

  logic         pkt_vld_q;
  logic [3:0]   idx_q;
  ssf_pkt_t     pkt_q;
  logic         out_vld_q;
  logic [7:0]   out_byte_q;
  logic         out_last_q;
  logic         adv, issue, last_idx;
  logic [111:0] pkt_bytes;
  logic [7:0]   byte_c;

  // output register moves when empty or being popped
  assign adv      = !out_vld_q || pop_i;
  assign issue    = adv && pkt_vld_q;
  assign last_idx = (idx_q == LAST_IDX);
  assign in_rdy_o = !pkt_vld_q || (issue && last_idx);

  // packet bytes in send order, little-endian fields
  assign pkt_bytes = {pkt_q.stamp, pkt_q.fbits, HDR1, HDR0};
  assign byte_c    = pkt_bytes[8*idx_q +: 8];

  assign empty_o = !out_vld_q;
  assign byte_o  = out_byte_q;
  assign last_o  = out_last_q;

  // byte counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_rdy_o && in_vld_i) begin
        pkt_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (issue) begin
        if (last_idx) begin
          pkt_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (adv) begin
        out_vld_q <= pkt_vld_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      pkt_q <= pkt_i;
    end
    if (adv) begin
      out_byte_q <= byte_c;
      out_last_q <= last_idx;
    end
  end

  // a packet never breaks off in the middle
  a_pkt_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && out_vld_q && !out_last_q) |=> out_vld_q)
    else $error("packet byte missing after pop");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_vld_q |-> (idx_q <= LAST_IDX))
    else $error("byte index past end of packet");

endmodule

FILE: rtl/core/scope_sample_framer.sv
// Channel   Handshake            Payload
// input     push / full          first_of_chunk_i, current_time_us_i, chunk_samples_i,
//                                gain_mode_i, channel_ok_i, calibrated_mv_i
// result    pop / empty          out_byte_o, last_of_packet_o
// config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// Items enter one per cycle while the two-stage front pipe and the entry queue have room;
// an item off the measured channel only steps the stamp and needs no back-end time.
// A measured sample yields 14 bytes, one per cycle from the byte serializer while popped;
// the serializer thus sets the sustained rate of measured samples.
// Reset clears stamp and all valid flags and presets the registers; no clearing pass.
// Holding off pop stalls serializer, float unit and queue in turn, then raises full.
module scope_sample_framer #(
  parameter int unsigned CHUNK_MAX   = ssf_pkg::CHUNK_MAX_DEF,
  parameter int unsigned QUEUE_DEPTH = ssf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        first_of_chunk_i,
  input  logic [63:0] current_time_us_i,
  input  logic [8:0]  chunk_samples_i,
  input  logic [1:0]  gain_mode_i,
  input  logic        channel_ok_i,
  input  logic [11:0] calibrated_mv_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_of_packet_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import ssf_pkg::*;

  ssf_cal_t    cal_q;
  ssf_timing_t tcfg_q;

  logic        q_push, q_full, q_empty, flt_rdy;
  ssf_entry_t  q_in, q_out;
  logic        flt_vld, ser_rdy;
  ssf_pkt_t    flt_pkt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.gain[RANGE_HIGH]   <= GAIN_HIGH_RST;
      cal_q.gain[RANGE_MID]    <= GAIN_MID_RST;
      cal_q.gain[RANGE_LOW]    <= GAIN_LOW_RST;
      cal_q.offset[RANGE_HIGH] <= OFF_HIGH_RST;
      cal_q.offset[RANGE_MID]  <= OFF_MID_RST;
      cal_q.offset[RANGE_LOW]  <= OFF_LOW_RST;
      tcfg_q.period            <= PERIOD_RST;
      tcfg_q.window            <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_HIGH: cal_q.gain[RANGE_HIGH]   <= cfg_wdata_i;
        CFG_GAIN_MID:  cal_q.gain[RANGE_MID]    <= cfg_wdata_i;
        CFG_GAIN_LOW:  cal_q.gain[RANGE_LOW]    <= cfg_wdata_i;
        CFG_OFF_HIGH:  cal_q.offset[RANGE_HIGH] <= cfg_wdata_i[27:0];
        CFG_OFF_MID:   cal_q.offset[RANGE_MID]  <= cfg_wdata_i[27:0];
        CFG_OFF_LOW:   cal_q.offset[RANGE_LOW]  <= cfg_wdata_i[27:0];
        CFG_PERIOD:    tcfg_q.period            <= cfg_wdata_i[15:0];
        CFG_WINDOW:    tcfg_q.window            <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // front end: timestamp keeping and channel filter
  ssf_front #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .first_i   (first_of_chunk_i),
    .now_i     (current_time_us_i),
    .count_i   (chunk_samples_i),
    .mode_i    (gain_mode_i),
    .ok_i      (channel_ok_i),
    .mv_i      (calibrated_mv_i),
    .tcfg_i    (tcfg_q),
    .q_push_o  (q_push),
    .q_entry_o (q_in),
    .q_full_i  (q_full)
  );

  // entry queue between front and back
  ssf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (flt_rdy),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // back end: voltage to single precision
  ssf_float u_float (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (!q_empty),
    .in_rdy_o  (flt_rdy),
    .entry_i   (q_out),
    .cal_i     (cal_q),
    .out_vld_o (flt_vld),
    .out_rdy_i (ser_rdy),
    .out_pkt_o (flt_pkt)
  );

  // back end: packet byte serializer
  ssf_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (flt_vld),
    .in_rdy_o (ser_rdy),
    .pkt_i    (flt_pkt),
    .pop_i    (pop),
    .empty_o  (empty),
    .byte_o   (out_byte_o),
    .last_o   (last_of_packet_o)
  );

endmodule

FILE: test/scope_sample_framer_tb.sv
`timescale 1ns / 1ps

module scope_sample_framer_tb;
  import ssf_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RST_CYCLES     = 6;
  localparam int CHUNK_MAX      = CHUNK_MAX_DEF;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TAIL_CYCLES    = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int RAND_PER_PHASE = 32;
  localparam int NUM_PHASES     = 5;
  localparam int TIMEOUT_CYCLES = 1000000;

  // Mode code with no range of its own; the block treats it as the low range
  localparam logic [1:0] RANGE_UNUSED = 2'd3;

  // One input request
  typedef struct packed {
    logic        first;
    logic [63:0] now;
    logic [8:0]  count;
    logic [1:0]  mode;
    logic        ok;
    logic [11:0] mv;
  } sample_t;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // Directed table row: either a register write or an input request
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [31:0] wdata;
    sample_t     s;
    bit          typed;
    logic [31:0] fbits;
    logic [63:0] stamp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        first_of_chunk_i;
  logic [63:0] current_time_us_i;
  logic [8:0]  chunk_samples_i;
  logic [1:0]  gain_mode_i;
  logic        channel_ok_i;
  logic [11:0] calibrated_mv_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte_o;
  logic        last_of_packet_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  // Shadow of the block's registers and stamp
  logic [31:0] gain_sh [3];
  logic [27:0] offset_sh [3];
  logic [15:0] period_sh;
  logic [15:0] window_sh;
  logic [63:0] stamp_q;

  pkt_byte_t pkt_bytes_q [$];
  dir_row_t  dir_q [$];
  int        mismatch_cnt = 0;
  int        burst_left   = 0;
  bit        hold_req     = 1'b0;

  scope_sample_framer u_top (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .first_of_chunk_i,
    .current_time_us_i,
    .chunk_samples_i,
    .gain_mode_i,
    .channel_ok_i,
    .calibrated_mv_i,
    .empty,
    .pop,
    .out_byte_o,
    .last_of_packet_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Exact (mv*2^16 - off) * gain / (1000 * 2^40), rounded to nearest even single
  function automatic logic [31:0] volts_bits(logic [11:0] mv, logic [27:0] off,
                                             logic [31:0] gain);
    logic signed [63:0] diff;
    logic               sgn;
    logic [63:0]        mag, m, q, r, mant, rest, half;
    int                 sh, p, drop;
    logic               up;
    logic [7:0]         ex;
    diff = $signed({36'd0, mv, 16'd0}) - $signed({36'd0, off});
    sgn  = diff[63];
    mag  = sgn ? 64'(-diff) : 64'(diff);
    m    = mag * {32'd0, gain};
    if (m == '0) return 32'd0;
    sh = 0;
    while (m < 64'h4000_0000_0000_0000) begin
      m = m << 1;
      sh++;
    end
    q = m / 64'(MV_PER_VOLT);
    r = m % 64'(MV_PER_VOLT);
    p = 63;
    while (q[p] == 1'b0) p--;
    drop = p - 23;
    mant = q >> drop;
    rest = q & ((64'd1 << drop) - 64'd1);
    half = 64'd1 << (drop - 1);
    up   = (rest > half) || (rest == half && (r != '0 || mant[0]));
    if (up) begin
      mant = mant + 64'd1;
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        p++;
      end
    end
    ex = 8'(p - sh - 40 + 127);
    return {sgn, ex, mant[22:0]};
  endfunction

  // Advance the stamp for one accepted request and work out its packet
  task automatic predict_packet(input sample_t s, output bit has_pkt,
                                output logic [31:0] fbits, output logic [63:0] stamp);
    logic [63:0] drift;
    logic [8:0]  n;
    int          sel;
    if (s.first) begin
      drift = (s.now > stamp_q) ? s.now - stamp_q : stamp_q - s.now;
      n     = (s.count > CHUNK_MAX) ? 9'(CHUNK_MAX) : s.count;
      if (stamp_q == '0 || drift > {48'd0, window_sh})
        stamp_q = s.now - 64'(n) * 64'(period_sh);
    end
    has_pkt = s.ok;
    sel     = (s.mode > 2'(RANGE_LOW)) ? int'(RANGE_LOW) : int'(s.mode);
    fbits   = volts_bits(s.mv, offset_sh[sel], gain_sh[sel]);
    stamp   = stamp_q;
    stamp_q = stamp_q + 64'(period_sh);
  endtask

  // Header, float bytes and stamp bytes, little-endian
  task automatic queue_packet(input logic [31:0] fbits, input logic [63:0] stamp);
    logic [7:0] pkt [PKT_LEN];
    pkt[0] = HDR0;
    pkt[1] = HDR1;
    for (int k = 0; k < 4; k++) pkt[2 + k] = fbits[8*k +: 8];
    for (int k = 0; k < 8; k++) pkt[6 + k] = stamp[8*k +: 8];
    for (int k = 0; k < PKT_LEN; k++)
      pkt_bytes_q.push_back('{data: pkt[k], last: (k == PKT_LEN - 1)});
  endtask

  // Offer one request and wait until the block takes it
  task automatic send_item(input sample_t s, input bit typed,
                           input logic [31:0] t_fbits, input logic [63:0] t_stamp);
    bit          has_pkt;
    logic [31:0] fbits;
    logic [63:0] stamp;
    push              <= 1'b1;
    first_of_chunk_i  <= s.first;
    current_time_us_i <= s.now;
    chunk_samples_i   <= s.count;
    gain_mode_i       <= s.mode;
    channel_ok_i      <= s.ok;
    calibrated_mv_i   <= s.mv;
    do @(posedge clk_i); while (full);
    predict_packet(s, has_pkt, fbits, stamp);
    if (has_pkt) queue_packet(typed ? t_fbits : fbits, typed ? t_stamp : stamp);
  endtask

  // Burst pacing between requests; no gaps while the receiver is held off
  task automatic pace();
    int gap;
    if (hold_req || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      gap = $urandom_range(1, 30);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_GAIN_HIGH, CFG_GAIN_MID, CFG_GAIN_LOW: gain_sh[int'(idx)] = data;
      CFG_OFF_HIGH, CFG_OFF_MID, CFG_OFF_LOW:
        offset_sh[int'(idx) - int'(CFG_OFF_HIGH)] = data[27:0];
      CFG_PERIOD: period_sh = data[15:0];
      CFG_WINDOW: window_sh = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // All bytes out, then room for off-channel requests still in the pipe
  task automatic wait_idle();
    while (pkt_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_item(input logic first, input logic [63:0] now, input logic [8:0] count,
                          input logic [1:0] mode, input logic ok, input logic [11:0] mv,
                          input bit typed = 1'b0, input logic [31:0] fbits = '0,
                          input logic [63:0] stamp = '0);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = CFG_GAIN_HIGH;
    row.wdata  = '0;
    row.s      = '{first: first, now: now, count: count, mode: mode, ok: ok, mv: mv};
    row.typed  = typed;
    row.fbits  = fbits;
    row.stamp  = stamp;
    dir_q.push_back(row);
  endtask

  task automatic add_cfg(input cfg_idx_e idx, input logic [31:0] data);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = data;
    row.s      = '0;
    row.typed  = 1'b0;
    row.fbits  = '0;
    row.stamp  = '0;
    dir_q.push_back(row);
  endtask

  // Receiver: random stretches of popping and stalling, plus one long hold-off
  initial begin
    int style;
    int len;
    pop <= 1'b0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        style = $urandom_range(0, 2);
        len   = $urandom_range(1, 24);
        repeat (len) begin
          case (style)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= 1'b0;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Check every popped byte against the oldest expected one
  always @(posedge clk_i) begin
    pkt_byte_t want;
    if (rst_ni && pop && !empty) begin
      if (pkt_bytes_q.size() == 0) begin
        $error("unexpected byte: out_byte_o=%02h last_of_packet_o=%0b",
               out_byte_o, last_of_packet_o);
        mismatch_cnt++;
      end else begin
        want = pkt_bytes_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte_o: expected %02h, actual %02h", want.data, out_byte_o);
          mismatch_cnt++;
        end
        if (last_of_packet_o !== want.last) begin
          $error("last_of_packet_o: expected %0b, actual %0b", want.last, last_of_packet_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sample_t     s;
    dir_row_t    row;
    bit          pushing;
    int          chunk_left;
    int          w;
    logic [31:0] g [3];
    logic [27:0] o [3];
    logic [15:0] per;
    logic [15:0] win;

    rst_ni            <= 1'b0;
    push              <= 1'b0;
    first_of_chunk_i  <= 1'b0;
    current_time_us_i <= '0;
    chunk_samples_i   <= '0;
    gain_mode_i       <= '0;
    channel_ok_i      <= 1'b0;
    calibrated_mv_i   <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= '0;
    cfg_wdata_i       <= '0;
    gain_sh[0]   = GAIN_HIGH_RST;
    gain_sh[1]   = GAIN_MID_RST;
    gain_sh[2]   = GAIN_LOW_RST;
    offset_sh[0] = OFF_HIGH_RST;
    offset_sh[1] = OFF_MID_RST;
    offset_sh[2] = OFF_LOW_RST;
    period_sh    = PERIOD_RST;
    window_sh    = WINDOW_RST;
    stamp_q      = '0;

    // Directed table
    // stamp zero forces a resync even inside the window; other channel gives no packet
    add_item(1'b1, 64'd500, 9'd2, RANGE_MID, 1'b0, 12'd0);
    add_item(1'b0, 64'd0, 9'd0, RANGE_HIGH, 1'b1, 12'd4095);
    add_item(1'b0, 64'd0, 9'd0, RANGE_HIGH, 1'b1, 12'd0);
    add_item(1'b0, 64'd0, 9'd0, RANGE_MID, 1'b1, 12'd2048);
    add_item(1'b0, 64'd0, 9'd0, RANGE_LOW, 1'b1, 12'd1);
    add_item(1'b0, 64'd0, 9'd0, RANGE_UNUSED, 1'b1, 12'd4095);
    // drift of zero: no resync
    add_item(1'b1, 64'd900, 9'd5, RANGE_HIGH, 1'b1, 12'd1500);
    // stamp at the top of the range, then wraps
    add_item(1'b1, '1, 9'd0, RANGE_HIGH, 1'b1, 12'd1000);
    add_item(1'b0, 64'd0, 9'd0, RANGE_MID, 1'b1, 12'd3000);
    // oversized chunk is clamped
    add_item(1'b1, 64'd1000000, 9'd511, RANGE_LOW, 1'b1, 12'd4000);
    // zero period, zero gain, zero window
    add_cfg(CFG_PERIOD, 32'd0);
    add_cfg(CFG_GAIN_HIGH, 32'd0);
    add_cfg(CFG_WINDOW, 32'd0);
    add_item(1'b1, 64'd777, 9'd300, RANGE_HIGH, 1'b1, 12'd4095, 1'b1, 32'd0, 64'd777);
    add_item(1'b0, 64'd0, 9'd0, RANGE_HIGH, 1'b1, 12'd0, 1'b1, 32'd0, 64'd777);
    // offset equal to the reading: exact zero
    add_cfg(CFG_OFF_MID, 32'd65536000);
    add_item(1'b0, 64'd0, 9'd0, RANGE_MID, 1'b1, 12'd1000, 1'b1, 32'd0, 64'd777);
    add_cfg(CFG_OFF_LOW, 32'h0FFF_FFFF);
    add_cfg(CFG_GAIN_LOW, 32'hFFFF_FFFF);
    add_item(1'b0, 64'd0, 9'd0, RANGE_LOW, 1'b1, 12'd0);
    add_item(1'b0, 64'd0, 9'd0, RANGE_LOW, 1'b1, 12'd4095);
    add_cfg(CFG_PERIOD, 32'd65535);
    add_cfg(CFG_WINDOW, 32'd65535);
    add_item(1'b1, 64'h8000_0000_0000_0000, 9'd256, RANGE_MID, 1'b1, 12'd4095);
    add_item(1'b0, 64'd0, 9'd0, RANGE_HIGH, 1'b0, 12'd123);

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    pushing = 1'b0;
    foreach (dir_q[k]) begin
      row = dir_q[k];
      if (row.is_cfg) begin
        if (pushing) push <= 1'b0;
        pushing = 1'b0;
        wait_idle();
        write_reg(row.idx, row.wdata);
      end else begin
        if (pushing) pace();
        send_item(row.s, row.typed, row.fbits, row.stamp);
        pushing = 1'b1;
      end
    end
    if (pushing) push <= 1'b0;

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          g = '{GAIN_HIGH_RST, GAIN_MID_RST, GAIN_LOW_RST};
          o = '{OFF_HIGH_RST, OFF_MID_RST, OFF_LOW_RST};
          per = PERIOD_RST;
          win = WINDOW_RST;
        end
        1: begin
          g = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
          o = '{28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF};
          per = 16'hFFFF;
          win = 16'hFFFF;
        end
        2: begin
          g = '{32'd1, 32'd1, 32'd1};
          o = '{28'd0, 28'd0, 28'd0};
          per = 16'd1;
          win = 16'd0;
        end
        3: begin
          foreach (g[k]) g[k] = $urandom;
          foreach (o[k]) o[k] = 28'($urandom);
          per = 16'($urandom_range(1, 65535));
          win = 16'($urandom_range(0, 65535));
        end
        default: begin
          foreach (g[k]) g[k] = $urandom;
          foreach (o[k]) o[k] = 28'($urandom);
          per = 16'($urandom_range(1, 200));
          win = 16'($urandom_range(0, 3000));
        end
      endcase
      write_reg(CFG_GAIN_HIGH, g[0]);
      write_reg(CFG_GAIN_MID, g[1]);
      write_reg(CFG_GAIN_LOW, g[2]);
      write_reg(CFG_OFF_HIGH, 32'(o[0]));
      write_reg(CFG_OFF_MID, 32'(o[1]));
      write_reg(CFG_OFF_LOW, 32'(o[2]));
      write_reg(CFG_PERIOD, 32'(per));
      write_reg(CFG_WINDOW, 32'(win));

      // long receiver hold-off while the sender keeps offering
      if (ph == 3) hold_req = 1'b1;

      chunk_left = 0;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        // chunk start, sometimes in the middle of a chunk
        if (chunk_left == 0 || $urandom_range(0, 15) == 0) begin
          s.first = 1'b1;
          case ($urandom_range(0, 3))
            0: s.now = {$urandom, $urandom};
            1: s.now = stamp_q;
            2: begin
              w     = int'(window_sh) + 8;
              s.now = stamp_q + 64'($urandom_range(0, 2 * w)) - 64'(w);
            end
            default: s.now = stamp_q + 64'($urandom_range(0, 100000));
          endcase
          s.count = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511))
                                                : 9'($urandom_range(0, 40));
          chunk_left = $urandom_range(1, 8);
        end else begin
          s.first = 1'b0;
          s.now   = {$urandom, $urandom};
          s.count = 9'($urandom_range(0, 511));
        end
        chunk_left--;
        s.mode = 2'($urandom_range(0, 3));
        s.ok   = ($urandom_range(0, 19) < 17);
        case ($urandom_range(0, 7))
          0: s.mv = 12'd0;
          1: s.mv = 12'd4095;
          default: s.mv = 12'($urandom_range(0, 4095));
        endcase
        if (i > 0) pace();
        send_item(s, 1'b0, '0, '0);
      end
      push <= 1'b0;
    end

    // Drain and finish
    while (pkt_bytes_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pkt_bytes_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ssf_pkg.sv
rtl/core/ssf_front.sv
rtl/core/ssf_queue.sv
rtl/core/ssf_float.sv
rtl/core/ssf_serial.sv
rtl/core/scope_sample_framer.sv
test/scope_sample_framer_tb.sv
